FILE: src/ncs_pkg.sv
// shared payload types and binary64 constants for the compensated sum core
package ncs_pkg;

	localparam int unsigned FpWidth = 64;
	localparam int unsigned ExpWidth = 11;
	localparam int unsigned FracWidth = 52;

	localparam logic [FpWidth-1:0] PosZero = 64'h0000_0000_0000_0000;
	localparam logic [FpWidth-1:0] DefaultNan = 64'hFFF8_0000_0000_0000;
	localparam logic [ExpWidth-1:0] ExpMax = 11'h7FF;

	typedef struct packed {
		logic [FpWidth-1:0] summand_bits;
		logic               start_new;
	} item_t;

	typedef struct packed {
		logic [FpWidth-1:0] sum_bits;
		logic [FpWidth-1:0] error_bits;
	} result_t;

endpackage

FILE: src/ncs_fp_add.sv
// binary64 adder and subtractor, round to nearest even, first-operand nan priority
module ncs_fp_add (
	input  logic [63:0] a,
	input  logic [63:0] b,
	input  logic        sub,
	output logic [63:0] y
);
	import ncs_pkg::*;

	function automatic logic [5:0] lzc56(input logic [55:0] v);
		logic [5:0] n;
		n = 6'd56;
		for (int i = 0; i < 56; i++) begin
			if (v[i]) begin
				n = 6'(55 - i);
			end
		end
		return n;
	endfunction

	always_comb begin : add_blk
		logic sa, sb, s_big, s_small, nan_a, nan_b, inf_a, inf_b, swap, eff_sub;
		logic [10:0] xa, xb, x_big, x_small;
		logic [51:0] fa, fb, f_big, f_small;
		logic [11:0] e_big, e_small, d, e_norm, e_fin;
		logic [56:0] w_big, w_small, w_sh, w_sum, w_norm;
		logic lost;
		logic [5:0] lz;
		logic [11:0] shl;
		logic rnd;
		logic [53:0] m_rnd;

		sa = a[63];
		sb = b[63] ^ sub;
		xa = a[62:52];
		xb = b[62:52];
		fa = a[51:0];
		fb = b[51:0];
		nan_a = (xa == ExpMax) && (fa != '0);
		nan_b = (xb == ExpMax) && (fb != '0);
		inf_a = (xa == ExpMax) && (fa == '0);
		inf_b = (xb == ExpMax) && (fb == '0);
		swap = {xb, fb} > {xa, fa};
		s_big = swap ? sb : sa;
		s_small = swap ? sa : sb;
		x_big = swap ? xb : xa;
		x_small = swap ? xa : xb;
		f_big = swap ? fb : fa;
		f_small = swap ? fa : fb;
		eff_sub = s_big ^ s_small;
		e_big = {1'b0, (x_big == '0) ? 11'd1 : x_big};
		e_small = {1'b0, (x_small == '0) ? 11'd1 : x_small};
		d = e_big - e_small;
		w_big = {1'b0, (x_big != '0), f_big, 3'b000};
		w_small = {1'b0, (x_small != '0), f_small, 3'b000};
		if (d >= 12'd57) begin
			w_sh = '0;
			lost = (w_small != '0);
		end else begin
			w_sh = w_small >> d;
			lost = ((w_sh << d) != w_small);
		end
		w_sh[0] = w_sh[0] | lost;
		w_sum = eff_sub ? (w_big - w_sh) : (w_big + w_sh);
		lz = lzc56(w_sum[55:0]);
		if (w_sum[56]) begin
			w_norm = {1'b0, w_sum[56:2], w_sum[1] | w_sum[0]};
			e_norm = e_big + 12'd1;
			shl = '0;
		end else begin
			shl = ({6'd0, lz} < e_big) ? {6'd0, lz} : (e_big - 12'd1);
			w_norm = w_sum << shl;
			e_norm = e_big - shl;
		end
		rnd = w_norm[2] & (w_norm[1] | w_norm[0] | w_norm[3]);
		m_rnd = {1'b0, w_norm[55:3]} + {53'd0, rnd};
		if (m_rnd[53]) begin
			e_fin = e_norm + 12'd1;
		end else if (m_rnd[52]) begin
			e_fin = e_norm;
		end else begin
			e_fin = '0;
		end

		if (nan_a) begin
			y = a | 64'h0008_0000_0000_0000;
		end else if (nan_b) begin
			y = b | 64'h0008_0000_0000_0000;
		end else if (inf_a || inf_b) begin
			if (inf_a && inf_b && (sa != sb)) begin
				y = DefaultNan;
			end else begin
				y = {inf_a ? sa : sb, ExpMax, 52'd0};
			end
		end else if (w_sum == '0) begin
			y = {sa & sb, 63'd0};
		end else if (e_fin >= {1'b0, ExpMax}) begin
			y = {s_big, ExpMax, 52'd0};
		end else begin
			y = {s_big, e_fin[10:0], m_rnd[53] ? 52'd0 : m_rnd[51:0]};
		end
	end

endmodule

FILE: src/ncs_step.sv
// pipelined compensated summation step: new sum, rounding error, new error term
module ncs_step (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        v_in,
	input  logic [63:0] summand,
	input  logic        start_new,
	output logic        v_out,
	output logic [63:0] sum_out,
	output logic [63:0] err_out
);
	import ncs_pkg::*;

	logic [63:0] s, e, total, big, small_op, diff, fix;
	logic s_nan, x_nan, s_larger;
	logic [63:0] sum_q, err_q;
	logic        v_s2, v_s3, v_s4;
	logic [63:0] total_s2, big_s2, small_s2;
	logic [63:0] total_s3, diff_s3, small_s3;
	logic [63:0] total_s4, fix_s4;
	logic        start_s2, start_s3, start_s4;

	// sum recurs through the first add only
	assign s = start_new ? PosZero : sum_q;
	assign s_nan = (s[62:52] == ExpMax) && (s[51:0] != '0);
	assign x_nan = (summand[62:52] == ExpMax) && (summand[51:0] != '0);
	assign s_larger = !s_nan && !x_nan && (s[62:0] > summand[62:0]);
	assign big = s_larger ? s : summand;
	assign small_op = s_larger ? summand : s;

	ncs_fp_add u_total (.a(s), .b(summand), .sub(1'b0), .y(total));
	ncs_fp_add u_diff (.a(big_s2), .b(total_s2), .sub(1'b1), .y(diff));
	ncs_fp_add u_fix (.a(diff_s3), .b(small_s3), .sub(1'b0), .y(fix));

	// error recurs through the last add only
	assign e = start_s4 ? PosZero : err_q;
	ncs_fp_add u_err (.a(e), .b(fix_s4), .sub(1'b0), .y(err_out));

	assign v_out = v_s4;
	assign sum_out = total_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			sum_q <= PosZero;
			err_q <= PosZero;
		end else if (en) begin
			v_s2 <= v_in;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			if (v_in) begin
				sum_q <= total;
			end
			if (v_s4) begin
				err_q <= err_out;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			total_s2 <= total;
			big_s2 <= big;
			small_s2 <= small_op;
			start_s2 <= start_new;
			total_s3 <= total_s2;
			diff_s3 <= diff;
			small_s3 <= small_s2;
			start_s3 <= start_s2;
			total_s4 <= total_s3;
			fix_s4 <= fix;
			start_s4 <= start_s3;
		end
	end

endmodule

FILE: src/neumaier_compensated_sum_core.sv
// top level of the streaming binary64 compensated (neumaier) accumulator
// Takes one binary64 summand per beat and returns the updated running sum and
// compensation term for every beat, one beat per cycle sustained while the
// result is not stalled. A beat is registered on input and then passes one
// binary64 add per stage: the sum, the difference, the fix-up and the error
// update, each in its own cycle, so the sum and the error each recur through
// a single add. The result register follows the s4 registers of the step. A
// stalled result freezes the whole pipeline, and the input stalls once its
// register holds a beat. start_new makes the step treat the stored sum and
// error as +0.0. Reset sets both to +0.0. NaN and infinity follow IEEE rules.
module neumaier_compensated_sum_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_stall,
	input  ncs_pkg::item_t  item,
	output logic            res_valid,
	input  logic            res_stall,
	output ncs_pkg::result_t res
);
	import ncs_pkg::*;

	logic        v_s1;
	item_t       item_s1;
	logic        adv;
	logic        step_valid;
	logic [63:0] step_sum, step_err;

	assign adv = !res_valid || !res_stall;
	assign item_stall = v_s1 && !adv;

	ncs_step u_step (
		.clk(clk),
		.arst_n(arst_n),
		.en(adv),
		.v_in(v_s1),
		.summand(item_s1.summand_bits),
		.start_new(item_s1.start_new),
		.v_out(step_valid),
		.sum_out(step_sum),
		.err_out(step_err)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			res_valid <= 1'b0;
		end else begin
			if (adv) begin
				res_valid <= step_valid;
			end
			if (!item_stall) begin
				v_s1 <= item_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			item_s1 <= item;
		end
		if (adv && step_valid) begin
			res.sum_bits <= step_sum;
			res.error_bits <= step_err;
		end
	end

endmodule

FILE: dv/tb_top.sv
// testbench for the streaming binary64 compensated sum core
`timescale 1ns / 1ps

module tb_top;
	import ncs_pkg::*;

	typedef struct {
		logic        fresh;
		logic [63:0] value;
		bit          typed;
		result_t     want;
	} row_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_stall;
	item_t   item = '0;
	logic    res_valid;
	logic    res_stall = 1'b0;
	result_t res;

	result_t pending_sums[$];
	real     acc_sum;
	real     acc_err;
	int      n_sent = 0;
	int      n_bad = 0;
	bit      quiet = 1'b0;
	bit      held = 1'b0;
	row_t    rows[$];

	neumaier_compensated_sum_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item      (item),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	always #10 clk = ~clk;

	function automatic bit is_nan(logic [63:0] b);
		return b[62:52] == ExpMax && b[51:0] != '0;
	endfunction

	// nan payloads are not pinned down, any nan matches any nan
	function automatic bit fp_match(logic [63:0] a, logic [63:0] b);
		return a === b || (is_nan(a) && is_nan(b));
	endfunction

	function automatic result_t accumulate(item_t it);
		real x, s, e, total, diff, fix;
		x = $bitstoreal(it.summand_bits);
		s = it.start_new ? 0.0 : acc_sum;
		e = it.start_new ? 0.0 : acc_err;
		total = s + x;
		if ($bitstoreal($realtobits(s) & 64'h7FFF_FFFF_FFFF_FFFF) >
		    $bitstoreal(it.summand_bits & 64'h7FFF_FFFF_FFFF_FFFF)) begin
			diff = s - total;
			fix = diff + x;
		end else begin
			diff = x - total;
			fix = diff + s;
		end
		e = e + fix;
		acc_sum = total;
		acc_err = e;
		return '{sum_bits: $realtobits(total), error_bits: $realtobits(e)};
	endfunction

	task automatic send_beat(item_t it, bit typed, result_t want);
		result_t got;
		item <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		got = accumulate(it);
		pending_sums.push_back(typed ? want : got);
		n_sent++;
	endtask

	task automatic idle_gap();
		if (!quiet && $urandom_range(0, 3) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	function automatic logic [63:0] rand_fp();
		logic [63:0] b;
		b = {$urandom, $urandom};
		case ($urandom_range(0, 5))
			0: ;
			1: b[62:52] = ExpMax;
			2: b[62:52] = '0;
			default: b[62:52] = 11'd1023 + 11'($urandom_range(0, 120)) - 11'd60;
		endcase
		return b;
	endfunction

	always @(posedge clk) begin
		result_t want;
		if (res_valid && !res_stall) begin
			if (pending_sums.size() == 0) begin
				$display("%0t: result with none expected, actual %h %h", $time,
					res.sum_bits, res.error_bits);
				n_bad++;
			end else begin
				want = pending_sums.pop_front();
				if (!fp_match(want.sum_bits, res.sum_bits)) begin
					$display("%0t: sum expected %h actual %h", $time,
						want.sum_bits, res.sum_bits);
					n_bad++;
				end
				if (!fp_match(want.error_bits, res.error_bits)) begin
					$display("%0t: error expected %h actual %h", $time,
						want.error_bits, res.error_bits);
					n_bad++;
				end
			end
		end
	end

	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			if (quiet) begin
				res_stall <= 1'b0;
				@(posedge clk);
			end else if (!held && n_sent >= 300) begin
				held = 1'b1;
				res_stall <= 1'b1;
				repeat (300) @(posedge clk);
			end else begin
				n = $urandom_range(1, 12);
				res_stall <= ($urandom_range(0, 2) == 0);
				repeat (n) @(posedge clk);
			end
		end
	end

	initial begin
		#5ms;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		item_t it;
		acc_sum = 0.0;
		acc_err = 0.0;
		rows = '{
			'{1'b0, 64'h3FF0_0000_0000_0000, 1, '{64'h3FF0_0000_0000_0000, PosZero}},
			'{1'b1, 64'h8000_0000_0000_0000, 1, '{PosZero, PosZero}},
			'{1'b1, 64'h7FEF_FFFF_FFFF_FFFF, 1, '{64'h7FEF_FFFF_FFFF_FFFF, PosZero}},
			'{1'b0, 64'h7FEF_FFFF_FFFF_FFFF, 0, '{PosZero, PosZero}},
			'{1'b1, 64'h4340_0000_0000_0000, 0, '{PosZero, PosZero}},
			'{1'b0, 64'h3FF0_0000_0000_0000, 0, '{PosZero, PosZero}},
			'{1'b0, 64'h3FF0_0000_0000_0000, 0, '{PosZero, PosZero}},
			'{1'b0, 64'hC340_0000_0000_0000, 0, '{PosZero, PosZero}},
			'{1'b1, 64'h3FF0_0000_0000_0000, 0, '{PosZero, PosZero}},
			'{1'b0, 64'hBFF0_0000_0000_0000, 0, '{PosZero, PosZero}},
			'{1'b1, 64'h0000_0000_0000_0001, 1, '{64'h0000_0000_0000_0001, PosZero}},
			'{1'b0, 64'h800F_FFFF_FFFF_FFFF, 0, '{PosZero, PosZero}},
			'{1'b1, 64'h7FF0_0000_0000_0000, 0, '{PosZero, PosZero}},
			'{1'b0, 64'hFFF0_0000_0000_0000, 0, '{PosZero, PosZero}},
			'{1'b1, DefaultNan, 0, '{PosZero, PosZero}},
			'{1'b0, 64'h3FF0_0000_0000_0000, 0, '{PosZero, PosZero}},
			'{1'b1, 64'h7FF0_0000_0000_0001, 0, '{PosZero, PosZero}},
			'{1'b1, 64'h3FB9_9999_9999_999A, 0, '{PosZero, PosZero}},
			'{1'b0, 64'h3FC9_9999_9999_999A, 0, '{PosZero, PosZero}},
			'{1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 0, '{PosZero, PosZero}}
		};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i]) begin
			idle_gap();
			send_beat('{summand_bits: rows[i].value, start_new: rows[i].fresh},
				rows[i].typed, rows[i].want);
		end
		for (int i = 0; i < 1000; i++) begin
			if (i == 500) begin
				item_valid <= 1'b0;
				wait (pending_sums.size() == 0);
				@(posedge clk);
			end
			if (i == 900) quiet = 1'b1;
			idle_gap();
			it.summand_bits = rand_fp();
			it.start_new = ($urandom_range(0, 19) == 0);
			send_beat(it, 0, '0);
		end
		item_valid <= 1'b0;
		wait (pending_sums.size() == 0);
		repeat (10) @(posedge clk);
		if (n_bad == 0 && pending_sums.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
